[hw/rtl/dnsmt_pkg.sv]
// Shared types and constants for the DNS response minimum-TTL scanner.
package dnsmt_pkg;

  localparam logic [7:0]  PTR_MASK  = 8'hC0;
  localparam logic [15:0] OPT_TYPE  = 16'd41;
  localparam logic [3:0]  HDR_LAST  = 4'd11;
  localparam logic [3:0]  FIXED_LAST = 4'd9;
  localparam logic [15:0] QTAIL_LEN = 16'd4;
  localparam logic [31:0] TTL_NONE  = 32'hFFFF_FFFF;

  localparam logic [2:0] ST_COMPLETE  = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR = 3'd1;
  localparam logic [2:0] ST_NO_REC    = 3'd2;
  localparam logic [2:0] ST_Q_FAULT   = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  typedef enum logic [10:0] {
    PH_HDR    = 11'b000_0000_0001,
    PH_NOREC  = 11'b000_0000_0010,
    PH_QNAME  = 11'b000_0000_0100,
    PH_QLABEL = 11'b000_0000_1000,
    PH_QTAIL  = 11'b000_0001_0000,
    PH_RNAME  = 11'b000_0010_0000,
    PH_RLABEL = 11'b000_0100_0000,
    PH_RPTR2  = 11'b000_1000_0000,
    PH_RFIXED = 11'b001_0000_0000,
    PH_RDATA  = 11'b010_0000_0000,
    PH_DONE   = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic [31:0] least_ttl;
    logic        cacheable;
    logic [2:0]  parse_status;
  } result_t;

endpackage

[hw/rtl/dns_response_min_ttl_scan_top.sv]
// Top level of the DNS response minimum-TTL scanner.
//
//   Channel | Direction | Word contents
//   in_     | input     | one response byte, tlast on the final byte
//   out_    | output    | least TTL, cacheable flag and status, one per response
//
// One byte is accepted per cycle when not stalled; each updates the parse state when taken.
// The result word appears in the output register in the cycle after the final byte is taken.
// The input stalls only while a result word waits in the output register and out_tready is low.
// Reset is synchronous and active low; it returns the parser to the header of a new response.
module dns_response_min_ttl_scan_top
  import dnsmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] least_ttl, [32] cacheable, [35:33] parse_status
);

  logic    take;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign take = in_tvalid && in_tready;

  dnsmt_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .msg_byte  (in_tdata),
    .last_byte (in_tlast),
    .res_valid (res_valid),
    .res       (res)
  );

  dnsmt_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res),
    .can_take  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {4'd0, out_res.parse_status, out_res.cacheable, out_res.least_ttl};

endmodule

[hw/rtl/dnsmt_parser.sv]
// Byte-wise parse state and minimum-TTL tracking for one DNS response.
module dnsmt_parser
  import dnsmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [7:0]  msg_byte,
  input  logic        last_byte,
  output logic        res_valid,
  output result_t     res
);

  phase_t      phase_r, phase_nxt, ph_t;
  logic [3:0]  hpos_r, hpos_nxt, hpos_t;
  logic [15:0] qleft_r, qleft_nxt, qleft_t;
  logic [15:0] rleft_r, rleft_nxt, rleft_t;
  logic [15:0] skip_r, skip_nxt, skip_t;
  logic [3:0]  fpos_r, fpos_nxt, fpos_t;
  logic [31:0] gw_r, gw_nxt, gw_t;
  logic [15:0] kind_r, kind_nxt, kind_t;
  logic [31:0] rmin_r, rmin_nxt, rmin_t;
  logic [2:0]  status;
  logic [31:0] ttl;

  always_comb begin
    ph_t    = phase_r;
    hpos_t  = hpos_r;
    qleft_t = qleft_r;
    rleft_t = rleft_r;
    skip_t  = skip_r;
    fpos_t  = fpos_r;
    gw_t    = gw_r;
    kind_t  = kind_r;
    rmin_t  = rmin_r;
    unique case (phase_r)
      PH_HDR: begin
        gw_t = {gw_r[23:0], msg_byte};
        if (hpos_r == 4'd5) begin
          qleft_t = gw_t[15:0];
        end else if (hpos_r == 4'd7 || hpos_r == 4'd9 || hpos_r == HDR_LAST) begin
          rleft_t = rleft_r + gw_t[15:0];
        end
        if (hpos_r == HDR_LAST) begin
          if (rleft_t == 16'd0) ph_t = PH_NOREC;
          else if (qleft_t == 16'd0) ph_t = PH_RNAME;
          else ph_t = PH_QNAME;
        end
        hpos_t = hpos_r + 4'd1;
      end
      PH_QNAME: begin
        if ((msg_byte & PTR_MASK) == PTR_MASK) begin
          skip_t = QTAIL_LEN + 16'd1;
          ph_t   = PH_QTAIL;
        end else if (msg_byte == 8'd0) begin
          skip_t = QTAIL_LEN;
          ph_t   = PH_QTAIL;
        end else begin
          skip_t = {8'd0, msg_byte};
          ph_t   = PH_QLABEL;
        end
      end
      PH_QLABEL: begin
        skip_t = skip_r - 16'd1;
        if (skip_t == 16'd0) ph_t = PH_QNAME;
      end
      PH_QTAIL: begin
        skip_t = skip_r - 16'd1;
        if (skip_t == 16'd0) begin
          qleft_t = qleft_r - 16'd1;
          ph_t    = (qleft_t == 16'd0) ? PH_RNAME : PH_QNAME;
        end
      end
      PH_RNAME: begin
        if ((msg_byte & PTR_MASK) == PTR_MASK) begin
          ph_t = PH_RPTR2;
        end else if (msg_byte == 8'd0) begin
          fpos_t = 4'd0;
          ph_t   = PH_RFIXED;
        end else begin
          skip_t = {8'd0, msg_byte};
          ph_t   = PH_RLABEL;
        end
      end
      PH_RLABEL: begin
        skip_t = skip_r - 16'd1;
        if (skip_t == 16'd0) ph_t = PH_RNAME;
      end
      PH_RPTR2: begin
        fpos_t = 4'd0;
        ph_t   = PH_RFIXED;
      end
      PH_RFIXED: begin
        if (fpos_r < 4'd2) begin
          kind_t = {kind_r[7:0], msg_byte};
        end else if (fpos_r >= 4'd4 && fpos_r < 4'd8) begin
          gw_t = {gw_r[23:0], msg_byte};
        end else if (fpos_r >= 4'd8) begin
          skip_t = {skip_r[7:0], msg_byte};
        end
        if (fpos_r == FIXED_LAST) begin
          if (kind_t != OPT_TYPE && gw_t < rmin_r) rmin_t = gw_t;
          if (skip_t == 16'd0) begin
            rleft_t = rleft_r - 16'd1;
            ph_t    = (rleft_t == 16'd0) ? PH_DONE : PH_RNAME;
          end else begin
            ph_t = PH_RDATA;
          end
        end
        fpos_t = fpos_r + 4'd1;
      end
      PH_RDATA: begin
        skip_t = skip_r - 16'd1;
        if (skip_t == 16'd0) begin
          rleft_t = rleft_r - 16'd1;
          ph_t    = (rleft_t == 16'd0) ? PH_DONE : PH_RNAME;
        end
      end
      PH_NOREC, PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (ph_t)
      PH_HDR:                            status = ST_SHORT_HDR;
      PH_NOREC:                          status = ST_NO_REC;
      PH_QNAME, PH_QLABEL, PH_QTAIL:     status = ST_Q_FAULT;
      PH_RNAME, PH_RLABEL, PH_RPTR2,
      PH_RFIXED, PH_RDATA:               status = ST_TRUNC;
      default:                           status = ST_COMPLETE;
    endcase
    if (status == ST_COMPLETE || status == ST_TRUNC) begin
      ttl = (rmin_t == TTL_NONE) ? 32'd0 : rmin_t;
    end else begin
      ttl = 32'd0;
    end
  end

  assign res_valid        = take & last_byte;
  assign res.least_ttl    = ttl;
  assign res.cacheable    = (ttl != 32'd0);
  assign res.parse_status = status;

  always_comb begin
    phase_nxt = phase_r;
    hpos_nxt  = hpos_r;
    qleft_nxt = qleft_r;
    rleft_nxt = rleft_r;
    skip_nxt  = skip_r;
    fpos_nxt  = fpos_r;
    gw_nxt    = gw_r;
    kind_nxt  = kind_r;
    rmin_nxt  = rmin_r;
    if (take) begin
      if (last_byte) begin
        phase_nxt = PH_HDR;
        hpos_nxt  = 4'd0;
        qleft_nxt = 16'd0;
        rleft_nxt = 16'd0;
        skip_nxt  = 16'd0;
        fpos_nxt  = 4'd0;
        gw_nxt    = 32'd0;
        kind_nxt  = 16'd0;
        rmin_nxt  = TTL_NONE;
      end else begin
        phase_nxt = ph_t;
        hpos_nxt  = hpos_t;
        qleft_nxt = qleft_t;
        rleft_nxt = rleft_t;
        skip_nxt  = skip_t;
        fpos_nxt  = fpos_t;
        gw_nxt    = gw_t;
        kind_nxt  = kind_t;
        rmin_nxt  = rmin_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      hpos_r  <= 4'd0;
      qleft_r <= 16'd0;
      rleft_r <= 16'd0;
      skip_r  <= 16'd0;
      fpos_r  <= 4'd0;
      gw_r    <= 32'd0;
      kind_r  <= 16'd0;
      rmin_r  <= TTL_NONE;
    end else begin
      phase_r <= phase_nxt;
      hpos_r  <= hpos_nxt;
      qleft_r <= qleft_nxt;
      rleft_r <= rleft_nxt;
      skip_r  <= skip_nxt;
      fpos_r  <= fpos_nxt;
      gw_r    <= gw_nxt;
      kind_r  <= kind_nxt;
      rmin_r  <= rmin_nxt;
    end
  end

endmodule

[hw/rtl/dnsmt_out_reg.sv]
// Result register that holds one word until the downstream side takes it.
module dnsmt_out_reg
  import dnsmt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_data,
  output logic    can_take,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    valid_r, valid_nxt;
  result_t data_r, data_nxt;

  assign can_take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (out_ready) valid_nxt = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[bench/dns_response_min_ttl_scan_top_tb.sv]
// Self-checking testbench for the DNS response minimum-TTL scanner top level.
`timescale 1ns / 100ps

module dns_response_min_ttl_scan_top_tb;
  import dnsmt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BYTES   = 1330;
  localparam int RANDOM_RESULTS = 15;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  dns_response_min_ttl_scan_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Scanner state mirrored byte by byte.
  phase_t      ph;
  logic [3:0]  hdr_idx;
  logic [15:0] qd_left;
  logic [15:0] rec_left;
  logic [15:0] skip_cnt;
  logic [3:0]  fix_idx;
  logic [31:0] shift_word;
  logic [15:0] rr_type;
  logic [31:0] ttl_floor;

  result_t     ttl_reports[$];
  logic [7:0]  frame[$];
  int          err_cnt = 0;
  int          frames_sent = 0;
  int          bytes_sent = 0;
  int          words_checked = 0;
  int          status_tally[8];
  int          in_gap_pct = 30;
  int          out_stall_pct = 30;
  int          stall_cnt = 0;
  int          quiet = 0;

  function automatic void clear_scan();
    ph = PH_HDR;
    hdr_idx = '0;
    qd_left = '0;
    rec_left = '0;
    skip_cnt = '0;
    fix_idx = '0;
    shift_word = '0;
    rr_type = '0;
    ttl_floor = TTL_NONE;
  endfunction

  function automatic void record_finished();
    rec_left = rec_left - 16'd1;
    ph = (rec_left == 16'd0) ? PH_DONE : PH_RNAME;
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic fin);
    result_t r;
    case (ph)
      PH_HDR: begin
        shift_word = {shift_word[23:0], b};
        if (hdr_idx == 4'd5) qd_left = shift_word[15:0];
        else if (hdr_idx == 4'd7 || hdr_idx == 4'd9 || hdr_idx == 4'd11)
          rec_left = rec_left + shift_word[15:0];
        if (hdr_idx == HDR_LAST) begin
          if (rec_left == 16'd0) ph = PH_NOREC;
          else if (qd_left == 16'd0) ph = PH_RNAME;
          else ph = PH_QNAME;
        end
        hdr_idx = hdr_idx + 4'd1;
      end
      PH_QNAME: begin
        if ((b & PTR_MASK) == PTR_MASK) begin
          skip_cnt = QTAIL_LEN + 16'd1;
          ph = PH_QTAIL;
        end else if (b == 8'h00) begin
          skip_cnt = QTAIL_LEN;
          ph = PH_QTAIL;
        end else begin
          skip_cnt = {8'h00, b};
          ph = PH_QLABEL;
        end
      end
      PH_QLABEL: begin
        skip_cnt = skip_cnt - 16'd1;
        if (skip_cnt == 16'd0) ph = PH_QNAME;
      end
      PH_QTAIL: begin
        skip_cnt = skip_cnt - 16'd1;
        if (skip_cnt == 16'd0) begin
          qd_left = qd_left - 16'd1;
          ph = (qd_left == 16'd0) ? PH_RNAME : PH_QNAME;
        end
      end
      PH_RNAME: begin
        if ((b & PTR_MASK) == PTR_MASK) ph = PH_RPTR2;
        else if (b == 8'h00) begin
          fix_idx = '0;
          ph = PH_RFIXED;
        end else begin
          skip_cnt = {8'h00, b};
          ph = PH_RLABEL;
        end
      end
      PH_RLABEL: begin
        skip_cnt = skip_cnt - 16'd1;
        if (skip_cnt == 16'd0) ph = PH_RNAME;
      end
      PH_RPTR2: begin
        fix_idx = '0;
        ph = PH_RFIXED;
      end
      PH_RFIXED: begin
        if (fix_idx < 4'd2) rr_type = {rr_type[7:0], b};
        else if (fix_idx >= 4'd4 && fix_idx < 4'd8) shift_word = {shift_word[23:0], b};
        else if (fix_idx >= 4'd8) skip_cnt = {skip_cnt[7:0], b};
        if (fix_idx == FIXED_LAST) begin
          if (rr_type != OPT_TYPE && shift_word < ttl_floor) ttl_floor = shift_word;
          if (skip_cnt == 16'd0) record_finished();
          else ph = PH_RDATA;
        end
        fix_idx = fix_idx + 4'd1;
      end
      PH_RDATA: begin
        skip_cnt = skip_cnt - 16'd1;
        if (skip_cnt == 16'd0) record_finished();
      end
      default: ;
    endcase
    if (fin) begin
      case (ph)
        PH_HDR:                       r.parse_status = ST_SHORT_HDR;
        PH_NOREC:                     r.parse_status = ST_NO_REC;
        PH_QNAME, PH_QLABEL, PH_QTAIL: r.parse_status = ST_Q_FAULT;
        PH_DONE:                      r.parse_status = ST_COMPLETE;
        default:                      r.parse_status = ST_TRUNC;
      endcase
      if (r.parse_status == ST_SHORT_HDR || r.parse_status == ST_NO_REC ||
          r.parse_status == ST_Q_FAULT)
        r.least_ttl = '0;
      else
        r.least_ttl = (ttl_floor == TTL_NONE) ? 32'd0 : ttl_floor;
      r.cacheable = (r.least_ttl != 32'd0);
      ttl_reports.push_back(r);
      clear_scan();
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (ttl_reports.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_tdata);
          err_cnt++;
        end else begin
          want = ttl_reports.pop_front();
          words_checked++;
          status_tally[want.parse_status]++;
          if (out_tdata[31:0] !== want.least_ttl) begin
            $display("%0t: least_ttl mismatch, expected %h, actual %h",
                     $time, want.least_ttl, out_tdata[31:0]);
            err_cnt++;
          end
          if (out_tdata[32] !== want.cacheable) begin
            $display("%0t: cacheable mismatch, expected %b, actual %b",
                     $time, want.cacheable, out_tdata[32]);
            err_cnt++;
          end
          if (out_tdata[35:33] !== want.parse_status) begin
            $display("%0t: parse_status mismatch, expected %0d, actual %0d",
                     $time, want.parse_status, out_tdata[35:33]);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else if (quiet == WATCHDOG_LIMIT) begin
      $display("dns_response_min_ttl_scan_top_tb: done, errors");
      $finish;
    end else quiet <= quiet + 1;
  end

  function automatic int idle_len(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (stall_cnt > 0) begin
      out_tready <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else begin
      out_tready <= 1'b1;
      stall_cnt <= idle_len(out_stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = idle_len(in_gap_pct);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= fin;
    @(posedge clk iff (in_tvalid && in_tready));
    bytes_sent++;
  endtask

  // Sends the first n bytes of the frame and marks the last of them.
  task automatic send_frame(input int n);
    for (int i = 0; i < n; i++) push_byte(frame[i], i == n - 1);
    frames_sent++;
    frame.delete();
  endtask

  function automatic void add16(input logic [15:0] v);
    frame.push_back(v[15:8]);
    frame.push_back(v[7:0]);
  endfunction

  function automatic void add32(input logic [31:0] v);
    add16(v[31:16]);
    add16(v[15:0]);
  endfunction

  function automatic void add_noise(input int n);
    for (int i = 0; i < n; i++) frame.push_back(8'($urandom));
  endfunction

  function automatic void add_header(input logic [15:0] qd, an, ns, ar);
    add16(16'($urandom));
    add16(16'($urandom));
    add16(qd);
    add16(an);
    add16(ns);
    add16(ar);
  endfunction

  function automatic void add_name(input int labels, input bit ptr, input bit long_label);
    int len;
    for (int i = 0; i < labels; i++) begin
      len = (long_label && i == 0) ? $urandom_range(64, 191) : $urandom_range(1, 8);
      frame.push_back(8'(len));
      add_noise(len);
    end
    if (ptr) begin
      frame.push_back(PTR_MASK | 8'($urandom_range(0, 63)));
      frame.push_back(8'($urandom));
    end else frame.push_back(8'h00);
  endfunction

  function automatic void add_question(input int labels, input bit ptr, input bit long_label);
    add_name(labels, ptr, long_label);
    add32($urandom);
  endfunction

  function automatic void add_record(input logic [15:0] rtype, input logic [31:0] ttl,
                                     input int rdlen, input int labels, input bit ptr);
    add_name(labels, ptr, 1'b0);
    add16(rtype);
    add16(16'($urandom));
    add32(ttl);
    add16(16'(rdlen));
    add_noise(rdlen);
  endfunction

  function automatic logic [31:0] pick_ttl();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return TTL_NONE;
      2:       return 32'hFFFF_FFFE;
      3:       return $urandom_range(1, 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_type();
    case ($urandom_range(0, 9))
      0, 1:    return OPT_TYPE;
      2:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_random_response();
    logic [15:0] qd, an, ns, ar;
    int total;
    qd = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 2));
    an = 16'($urandom_range(0, 3));
    ns = 16'($urandom_range(0, 1));
    ar = 16'($urandom_range(0, 2));
    if (an + ns + ar == 0) an = 16'd1;
    if ($urandom_range(0, 19) == 0) begin
      an = 16'd0;
      ns = 16'd0;
      ar = 16'd0;
    end
    add_header(qd, an, ns, ar);
    for (int i = 0; i < qd; i++)
      add_question($urandom_range(0, 3), $urandom_range(0, 9) < 4, $urandom_range(0, 29) == 0);
    total = int'(an) + int'(ns) + int'(ar);
    for (int i = 0; i < total; i++)
      add_record(pick_type(), pick_ttl(), $urandom_range(0, 8), $urandom_range(0, 2),
                 $urandom_range(0, 9) < 5);
    if ($urandom_range(0, 9) < 3) add_noise($urandom_range(1, 6));
  endfunction

  task automatic test_short_header();
    add_noise(1);
    send_frame(1);
    add_noise(5);
    send_frame(5);
    for (int i = 0; i < 11; i++) frame.push_back(8'hFF);
    send_frame(11);
  endtask

  task automatic test_empty_record_sections();
    add_header(16'd1, 16'd0, 16'd0, 16'd0);
    add_question(1, 1'b0, 1'b0);
    add_noise(3);
    send_frame(frame.size());
    // The three record counts add up to zero once the sum wraps.
    add_header(16'd0, 16'hFFFF, 16'd1, 16'd0);
    add_record(16'd1, 32'd60, 2, 0, 1'b1);
    send_frame(frame.size());
  endtask

  task automatic test_question_faults();
    add_header(16'd2, 16'd1, 16'd0, 16'd0);
    frame.push_back(8'd5);
    add_noise(2);
    send_frame(frame.size());
    add_header(16'd2, 16'd1, 16'd0, 16'd0);
    frame.push_back(8'hC0);
    send_frame(frame.size());
    add_header(16'd2, 16'd1, 16'd0, 16'd0);
    frame.push_back(8'h00);
    add_noise(2);
    send_frame(frame.size());
    add_header(16'd2, 16'd1, 16'd0, 16'd0);
    add_question(2, 1'b1, 1'b0);
    send_frame(frame.size());
  endtask

  task automatic test_complete_responses();
    add_header(16'd1, 16'd2, 16'd1, 16'd1);
    add_question(2, 1'b0, 1'b1);
    add_record(16'd1, 32'd3600, 4, 1, 1'b1);
    add_record(16'd28, 32'd300, 16, 2, 1'b0);
    add_record(OPT_TYPE, 32'd0, 0, 0, 1'b0);
    add_record(16'd2, 32'd86400, 3, 0, 1'b1);
    add_noise(4);
    send_frame(frame.size());
    add_header(16'd0, 16'd2, 16'd0, 16'd0);
    add_record(16'd5, TTL_NONE, 1, 0, 1'b1);
    add_record(16'd5, TTL_NONE, 0, 1, 1'b0);
    send_frame(frame.size());
    add_header(16'd1, 16'd1, 16'd0, 16'd0);
    add_question(0, 1'b1, 1'b0);
    add_record(16'd1, 32'd0, 4, 0, 1'b1);
    send_frame(frame.size());
    add_header(16'd0, 16'd1, 16'd0, 16'd1);
    add_record(16'hFFFF, 32'hFFFF_FFFE, 0, 0, 1'b1);
    add_record(OPT_TYPE, 32'd5, 2, 0, 1'b0);
    send_frame(frame.size());
    add_header(16'd0, 16'd0, 16'd0, 16'd1);
    add_record(OPT_TYPE, 32'd120, 0, 0, 1'b0);
    send_frame(frame.size());
  endtask

  task automatic test_truncated_records();
    logic [7:0] kept[$];
    int mark;
    int cuts[5];
    add_header(16'd0, 16'd3, 16'd0, 16'd0);
    add_record(16'd1, 32'd77, 2, 0, 1'b1);
    mark = frame.size();
    frame.push_back(8'd3);
    add_noise(3);
    frame.push_back(8'hC0);
    frame.push_back(8'h0C);
    add16(16'd1);
    add16(16'd1);
    add32(32'd10);
    add16(16'd4);
    add_noise(4);
    cuts = '{12, mark + 2, mark + 5, mark + 11, mark + 17};
    kept = frame;
    foreach (cuts[k]) begin
      frame = kept;
      send_frame(cuts[k]);
    end
  endtask

  task automatic test_random_traffic();
    int start_bytes;
    int start_frames;
    int n;
    start_bytes = bytes_sent;
    start_frames = frames_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES || frames_sent - start_frames < RANDOM_RESULTS)
    begin
      if ($urandom_range(0, 4) == 0) begin
        in_gap_pct = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct = 30;
        out_stall_pct = 30;
      end
      n = $urandom_range(0, 99);
      if (n < 70) begin
        add_random_response();
        send_frame(frame.size());
      end else if (n < 85) begin
        add_random_response();
        send_frame($urandom_range(1, frame.size()));
      end else begin
        add_noise($urandom_range(1, 40));
        send_frame(frame.size());
      end
    end
  endtask

  initial begin
    clear_scan();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_header();
    test_empty_record_sections();
    test_question_faults();
    test_complete_responses();
    test_truncated_records();
    test_random_traffic();
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    while (ttl_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Scanned %0d responses in %0d bytes, %0d result words checked.",
             frames_sent, bytes_sent, words_checked);
    $display("Status mix: complete %0d, short %0d, no records %0d, question fault %0d, trunc %0d.",
             status_tally[ST_COMPLETE], status_tally[ST_SHORT_HDR], status_tally[ST_NO_REC],
             status_tally[ST_Q_FAULT], status_tally[ST_TRUNC]);
    if (err_cnt == 0) $display("dns_response_min_ttl_scan_top_tb: done, clean");
    else $display("dns_response_min_ttl_scan_top_tb: done, errors");
    $finish;
  end

endmodule
